// File: src/orq_pkg.sv
// Shared types and constants for the overwriting ring queue.
// No dependencies; imported by orq_ctrl, orq_datapath and the top level.
`default_nettype none
package orq_pkg;

  // Storage geometry
  localparam int DEPTH        = 16;
  localparam int ELEMENT_BITS = 32;
  localparam int PTR_W        = $clog2(DEPTH);

  // Fixed field widths
  localparam int DATA_W   = 32;
  localparam int OFFSET_W = 4;
  localparam int CAP_W    = 5;
  localparam int SUM_W    = CAP_W + 1;

  // Bits actually kept per element: the input word is never wider than DATA_W
  localparam int STORE_BITS = (ELEMENT_BITS < DATA_W) ? ELEMENT_BITS : DATA_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_POP   = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic load_rd;  // capture storage read data into the result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_peek;  // the offered item is a peek
  } dp_stat_t;

endpackage
`default_nettype wire

// File: src/orq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module orq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/orq_ctrl.sv
// Controller: sequences one operation at a time and owns the result valid flag.
// Depends on orq_pkg.
`default_nettype none
module orq_ctrl import orq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        // Result slot is free or being drained this cycle
        in_ready   = !out_valid_r || out_ready;
        cmd.accept = in_valid && in_ready;
        if (cmd.accept) begin
          if (stat.is_peek) begin
            state_nxt = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        // Storage read data is ready; result slot is empty here
        cmd.load_rd   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: src/orq_datapath.sv
// Datapath: capacity register, ring pointers, element count, storage and result registers.
// Depends on orq_pkg and orq_ram.
`default_nettype none
module orq_datapath import orq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CAP_W-1:0]    cfg_wdata,
  input  wire logic [1:0]          in_operation,
  input  wire logic [DATA_W-1:0]   in_element_data,
  input  wire logic [OFFSET_W-1:0] in_read_offset,
  input  wire logic [CAP_W-1:0]    in_pop_amount,
  input  wire ctrl_cmd_t           cmd,
  output dp_stat_t                 stat,
  output logic                     out_status,
  output logic      [DATA_W-1:0]   out_read_data,
  output logic      [CAP_W-1:0]    out_occupancy
);

  logic [CAP_W-1:0] cap_r;
  logic [PTR_W-1:0] front_r, front_nxt;
  logic [PTR_W-1:0] back_r, back_nxt;
  logic [CAP_W-1:0] held_r, held_nxt;

  logic              status_r, status_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic [CAP_W-1:0]  occ_r;

  logic [CAP_W-1:0] cap_eff;
  logic [SUM_W-1:0] front_sum, peek_sum, back_sum;
  logic [SUM_W-1:0] front_wrap, peek_wrap, back_wrap;
  logic [CAP_W-1:0] front_add;
  logic [PTR_W-1:0] peek_addr;
  logic             ram_we;
  logic [STORE_BITS-1:0] ram_rdata;
  op_t              op;

  assign op           = op_t'(in_operation);
  assign stat.is_peek = (op == OP_PEEK);

  // Clamp the configured capacity into 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cap_r) > 32'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  // Modular pointer adds: every sum whose result is used stays below twice the capacity
  assign front_add  = (op == OP_PUSH) ? CAP_W'(1) : in_pop_amount;
  assign front_sum  = SUM_W'(CAP_W'(front_r)) + SUM_W'(front_add);
  assign front_wrap = (front_sum >= SUM_W'(cap_eff)) ? front_sum - SUM_W'(cap_eff) : front_sum;
  assign back_sum   = SUM_W'(CAP_W'(back_r)) + SUM_W'(1);
  assign back_wrap  = (back_sum >= SUM_W'(cap_eff)) ? back_sum - SUM_W'(cap_eff) : back_sum;
  assign peek_sum   = SUM_W'(CAP_W'(front_r)) + SUM_W'(in_read_offset);
  assign peek_wrap  = (peek_sum >= SUM_W'(cap_eff)) ? peek_sum - SUM_W'(cap_eff) : peek_sum;
  assign peek_addr  = PTR_W'(peek_wrap);

  // Operation decode
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    held_nxt   = held_r;
    status_nxt = 1'b0;
    ram_we     = 1'b0;
    case (op)
      OP_CLEAR: begin
        front_nxt = '0;
        back_nxt  = '0;
        held_nxt  = '0;
      end
      OP_PUSH: begin
        ram_we   = cmd.accept;
        back_nxt = PTR_W'(back_wrap);
        if (held_r >= cap_eff) begin
          // full: oldest entry overwritten
          front_nxt = PTR_W'(front_wrap);
          held_nxt  = cap_eff;
        end else begin
          held_nxt = held_r + CAP_W'(1);
        end
      end
      OP_PEEK: begin
        status_nxt = (CAP_W'(in_read_offset) >= held_r);
      end
      OP_POP: begin
        if (in_pop_amount > held_r) begin
          status_nxt = 1'b1;
        end else begin
          held_nxt  = held_r - in_pop_amount;
          front_nxt = PTR_W'(front_wrap);
        end
      end
      default: begin
        status_nxt = 1'b0;
      end
    endcase
  end

  // Queue state; a capacity write also empties the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      front_r <= '0;
      back_r  <= '0;
      held_r  <= '0;
    end else if (cfg_we) begin
      cap_r   <= cfg_wdata;
      front_r <= '0;
      back_r  <= '0;
      held_r  <= '0;
    end else if (cmd.accept) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      held_r  <= held_nxt;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= status_nxt;
      occ_r    <= held_nxt;
      rdata_r  <= '0;
    end else if (cmd.load_rd && !status_r) begin
      rdata_r <= DATA_W'(ram_rdata);
    end
  end

  orq_ram #(
    .WIDTH (STORE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (back_r),
    .wdata (in_element_data[STORE_BITS-1:0]),
    .re    (cmd.accept),
    .raddr (peek_addr),
    .rdata (ram_rdata)
  );

  assign out_status    = status_r;
  assign out_read_data = rdata_r;
  assign out_occupancy = occ_r;

endmodule
`default_nettype wire

// File: src/overwriting_ring_queue_top.sv
// Top level of the overwriting ring queue: controller plus datapath.
// Depends on orq_pkg, orq_ctrl, orq_datapath (and orq_ram below it).
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in_     | in_valid / in_ready  | operation, element_data, read_offset, pop_amount
//   out_    | out_valid / out_ready| status, read_data, occupancy
//   cfg_    | cfg_we (no wait)     | cfg_wdata (capacity in use)
//
// Clear, push and pop: the result register loads at the input transfer.
// A peek loads its read data in ST_READ, from the registered read port of the slot storage.
// A new item is taken in the cycle the pending result transfers out.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 16.
// A capacity write empties the queue as well; storage is never cleared.
`default_nettype none
module overwriting_ring_queue_top import orq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CAP_W-1:0]    cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_operation,
  input  wire logic [DATA_W-1:0]   in_element_data,
  input  wire logic [OFFSET_W-1:0] in_read_offset,
  input  wire logic [CAP_W-1:0]    in_pop_amount,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_status,
  output logic      [DATA_W-1:0]   out_read_data,
  output logic      [CAP_W-1:0]    out_occupancy
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  orq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  orq_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_operation),
    .in_element_data (in_element_data),
    .in_read_offset  (in_read_offset),
    .in_pop_amount   (in_pop_amount),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_occupancy   (out_occupancy)
  );

endmodule
`default_nettype wire
